// ===== rtl/core/srms_pkg.sv =====
// Shared types and constants of the sliding RMS level meter.
`timescale 1ns / 1ps
package srms_pkg;

	localparam int FRAC_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int Q_W     = 64;
	localparam int DB_W    = 27;

	localparam logic signed [DB_W-1:0] DB_PER_LOG2_Q16 = 27'sd50504453;
	localparam logic signed [Q_W-1:0]  FLOOR_Q32 = -(64'sd30720 <<< 32);
	localparam logic signed [Q_W-1:0]  CAL_Q32   = 64'sd50504453 <<< 16;
	localparam logic signed [Q_W-1:0]  ROUND_Q32 = 64'sd1 <<< 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOG_SUM,
		ST_LOG_WIN,
		ST_MUL,
		ST_PUBLISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_MUL,
		LG_ADJ
	} log_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic log_start;
		logic log_sel_win;
		logic mul;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic block_end;
		logic sum_zero;
		logic log_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/srms_log2.sv =====
// Iterative base-2 logarithm unit with a 16-bit fraction.
`timescale 1ns / 1ps
module srms_log2 import srms_pkg::*; #(
	parameter int NORM_W = 58,
	parameter int EW     = $clog2(NORM_W),
	parameter int LOG_W  = EW + FRAC_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NORM_W-1:0] x,
	output logic              done,
	output logic [LOG_W-1:0]  result
);

	log_state_t st_q, st_next;
	logic [NORM_W-1:0] norm_q;
	logic [EW-1:0] cnt_q;
	logic [31:0] m_q;
	logic [63:0] prod_q;
	logic [FRAC_W-1:0] frac_q;
	logic [3:0] bit_q;
	logic [32:0] sq_t;
	logic [EW-1:0] expo;

	assign sq_t = prod_q[63:31];
	assign expo = EW'(NORM_W - 1) - cnt_q;

	always_comb begin
		st_next = st_q;
		case (st_q)
			LG_IDLE: if (start) st_next = LG_NORM;
			LG_NORM: if (norm_q[NORM_W-1]) st_next = LG_MUL;
			LG_MUL:  st_next = LG_ADJ;
			LG_ADJ:  st_next = (bit_q == 4'd15) ? LG_IDLE : LG_MUL;
			default: st_next = LG_IDLE;
		endcase
	end

	always_comb begin
		done   = (st_q == LG_ADJ) && (bit_q == 4'd15);
		result = {expo, frac_q[FRAC_W-2:0], sq_t[32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= LG_IDLE;
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			st_q <= st_next;
			case (st_q)
				LG_IDLE: cnt_q <= '0;
				LG_NORM: begin
					bit_q <= '0;
					if (!norm_q[NORM_W-1]) cnt_q <= cnt_q + 1'b1;
				end
				LG_ADJ: bit_q <= bit_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			LG_IDLE: norm_q <= x;
			LG_NORM: begin
				if (norm_q[NORM_W-1]) begin
					m_q    <= norm_q[NORM_W-1 -: 32];
					frac_q <= '0;
				end else begin
					norm_q <= norm_q << 1;
				end
			end
			LG_MUL: prod_q <= m_q * m_q;
			LG_ADJ: begin
				frac_q <= {frac_q[FRAC_W-2:0], sq_t[32]};
				m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/srms_dp.sv =====
// Datapath: squaring, sample ring, running sum, level arithmetic and output register.
`timescale 1ns / 1ps
module srms_dp import srms_pkg::*; #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_end,
	input  logic                          cfg_we,
	input  logic [12:0]                   window_length,
	output logic signed [LEVEL_W-1:0]     level_db,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  dp_cmd_t                       cmd,
	output dp_sts_t                       sts
);

	localparam int SQ_W   = 2 * (SAMPLE_BITS - 1);
	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int WW     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SQ_W + AW;
	localparam int NORM_W = (SUM_W > 32) ? SUM_W : 32;
	localparam int EW     = $clog2(NORM_W);
	localparam int LOG_W  = EW + FRAC_W;
	localparam int D_W    = LOG_W + 2;
	localparam int P_W    = D_W + DB_W;
	localparam int RST_WIN = (2400 > MAX_WINDOW) ? MAX_WINDOW : 2400;
	localparam logic [SQ_W-1:0] CAP = {SQ_W{1'b1}};
	localparam logic signed [D_W-1:0] OFS = D_W'(SQ_W) <<< FRAC_W;

	logic [SQ_W-1:0] ring [MAX_WINDOW];
	logic [SQ_W-1:0] rd_q, sq_s1, sq;
	logic [SAMPLE_BITS-1:0] mag;
	logic [2*SAMPLE_BITS-1:0] sq_full;
	logic be_q;
	logic [SUM_W-1:0] sum_q;
	logic [AW-1:0] pos_q;
	logic [AW:0] pos_inc;
	logic wrap_q, wrap_now;
	logic [WW-1:0] win_q;
	logic [31:0] wl_ext, win_next;
	logic [NORM_W-1:0] log_x;
	logic log_done;
	logic [LOG_W-1:0] log_res, ls_q, lw_q;
	logic signed [D_W-1:0] d;
	logic signed [P_W-1:0] prod;
	logic signed [Q_W-1:0] q_q, q_f, r;
	logic out_valid_q;
	logic signed [LEVEL_W-1:0] level_q;

	always_comb begin
		mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
		sq_full = mag * mag;
		sq      = (sq_full > (2*SAMPLE_BITS)'(CAP)) ? CAP : sq_full[SQ_W-1:0];
		wl_ext  = 32'(window_length);
		if (wl_ext < 32'd32) win_next = 32'd32;
		else if (wl_ext > 32'(MAX_WINDOW)) win_next = 32'(MAX_WINDOW);
		else win_next = wl_ext;
		pos_inc  = {1'b0, pos_q} + 1'b1;
		wrap_now = 32'(pos_inc) >= 32'(win_q);
		log_x    = cmd.log_sel_win ? NORM_W'(win_q) : NORM_W'(sum_q);
		d        = $signed({2'b00, ls_q}) - $signed({2'b00, lw_q}) - OFS;
		prod     = d * DB_PER_LOG2_Q16;
		if (sts.sum_zero || (q_q < FLOOR_Q32)) q_f = FLOOR_Q32;
		else q_f = q_q;
		r = q_f + CAL_Q32 + ROUND_Q32;
	end

	srms_log2 #(.NORM_W(NORM_W)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.update) ring[pos_q] <= sq_s1;
		if (cmd.load) rd_q <= ring[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_s1 <= sq;
		end
		if (log_done) begin
			if (cmd.log_sel_win) lw_q <= log_res;
			else ls_q <= log_res;
		end
		if (cmd.mul) q_q <= Q_W'(prod);
		if (cmd.publish) level_q <= r[32 +: LEVEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WW'(RST_WIN);
			sum_q       <= '0;
			pos_q       <= '0;
			wrap_q      <= 1'b0;
			be_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) be_q <= block_end;
			if (cfg_we) begin
				win_q  <= WW'(win_next);
				sum_q  <= '0;
				pos_q  <= '0;
				wrap_q <= 1'b0;
			end else if (cmd.update) begin
				sum_q <= sum_q - (wrap_q ? SUM_W'(rd_q) : '0) + SUM_W'(sq_s1);
				if (wrap_now) begin
					pos_q  <= '0;
					wrap_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[AW-1:0];
				end
			end
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.block_end = be_q;
		sts.sum_zero  = (sum_q == '0);
		sts.log_done  = log_done;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign level_db  = level_q;

endmodule

// ===== rtl/core/srms_ctrl.sv =====
// Controller state machine sequencing the meter datapath.
`timescale 1ns / 1ps
module srms_ctrl import srms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	ctrl_state_t st_q, st_next;

	always_comb begin
		st_next = st_q;
		case (st_q)
			ST_IDLE:    if (in_valid) st_next = ST_UPDATE;
			ST_UPDATE:  st_next = sts.block_end ? ST_LOG_SUM : ST_IDLE;
			ST_LOG_SUM: begin
				if (sts.sum_zero) st_next = ST_PUBLISH;
				else if (sts.log_done) st_next = ST_LOG_WIN;
			end
			ST_LOG_WIN: if (sts.log_done) st_next = ST_MUL;
			ST_MUL:     st_next = ST_PUBLISH;
			ST_PUBLISH: if (sts.out_free) st_next = ST_IDLE;
			default:    st_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_UPDATE:  cmd.update = 1'b1;
			ST_LOG_SUM: cmd.log_start = !sts.sum_zero;
			ST_LOG_WIN: begin
				cmd.log_start   = 1'b1;
				cmd.log_sel_win = 1'b1;
			end
			ST_MUL:     cmd.mul = 1'b1;
			ST_PUBLISH: cmd.publish = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_next;
		end
	end

endmodule

// ===== rtl/core/sliding_rms_level_meter_unit.sv =====
// Top level of the sliding RMS level meter.
// An ordinary sample is accepted, then the ring and running sum are updated.
// A block-end sample with a nonzero sum adds two log2 runs on one shared unit, each made of
// start, normalize shift, mantissa load and 16 square steps (multiply, then adjust); then
// multiply and publish. The result sits in an output register while the
// next transaction is accepted. Reset is asynchronous; a wrap flag keeps unwritten ring slots out of the sum.
`timescale 1ns / 1ps
module sliding_rms_level_meter_unit import srms_pkg::*; #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [LEVEL_W-1:0]     level_db,
	input  logic                          cfg_we,
	input  logic [12:0]                   window_length
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	srms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	srms_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.block_end     (block_end),
		.cfg_we        (cfg_we),
		.window_length (window_length),
		.level_db      (level_db),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== rtl/core/srms_checker.sv =====
// Port-level checks of the level meter and their binding to the top level.
`timescale 1ns / 1ps
module srms_checker import srms_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [LEVEL_W-1:0] level_db
);

	// A held result must not change until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_db))
		else $error("output changed while stalled");

	// Published levels stay between the calibrated floor and full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(level_db) >= -16'sd29949) && ($signed(level_db) <= 16'sd1024))
		else $error("level out of range");

	// Every accepted transaction leaves the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

endmodule

bind sliding_rms_level_meter_unit srms_checker u_srms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level_db  (level_db)
);

// ===== tb/sv/sliding_rms_level_meter_unit_tb.sv =====
// Self-checking testbench of the sliding RMS level meter: random samples and windows, checked levels.
`timescale 1ns / 1ps
module sliding_rms_level_meter_unit_tb;
	import srms_pkg::*;

	localparam int RING_DEPTH  = 4096;
	localparam int SAMPLE_BITS = 24;
	localparam int WATCHDOG    = 20000;
	localparam int SETTLE      = 400;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          block_end = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [LEVEL_W-1:0]     level_db;
	logic                          cfg_we = 1'b0;
	logic [12:0]                   window_length = 13'd2400;

	longint unsigned square_ring [RING_DEPTH];
	longint unsigned ring_sum;
	int unsigned     ring_pos;
	logic [12:0]     meter_window;

	logic signed [LEVEL_W-1:0] expected_levels [$];
	int  mismatches = 0;
	bit  idle_on = 1'b1;
	int  stall_left = 0;
	int  quiet_cycles = 0;

	sliding_rms_level_meter_unit #(
		.MAX_WINDOW (RING_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_db     (level_db),
		.cfg_we       (cfg_we),
		.window_length(window_length)
	);

	always #10 clk = ~clk;

	function automatic int unsigned active_window();
		if (meter_window < 13'd32) return 32;
		if (meter_window > 13'd4096) return RING_DEPTH;
		return meter_window;
	endfunction

	function automatic longint unsigned log2_q16(longint unsigned x);
		int unsigned     e;
		longint unsigned m;
		longint unsigned frac;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> (e + 1)) != 0) e++;
		if (e >= 31) m = x >> (e - 31);
		else m = x << (31 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'd4294967296) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(e) << 16) | frac;
	endfunction

	function automatic logic signed [LEVEL_W-1:0] level_from_sum();
		longint q;
		longint d;
		if (ring_sum == 0) begin
			q = FLOOR_Q32;
		end else begin
			d = longint'(log2_q16(ring_sum)) - longint'(log2_q16(active_window()))
				- (longint'(2 * (SAMPLE_BITS - 1)) << 16);
			q = d * 64'sd50504453;
			if (q < FLOOR_Q32) q = FLOOR_Q32;
		end
		q = q + CAL_Q32 + ROUND_Q32;
		q = q >>> 32;
		return q[LEVEL_W-1:0];
	endfunction

	function automatic void clear_meter();
		foreach (square_ring[i]) square_ring[i] = 0;
		ring_sum = 0;
		ring_pos = 0;
	endfunction

	function automatic void predict_level(logic signed [SAMPLE_BITS-1:0] s, logic last);
		longint unsigned mag;
		longint unsigned sq;
		int unsigned     w;
		w = active_window();
		if (s == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) begin
			sq = (64'd1 << (2 * (SAMPLE_BITS - 1))) - 1;
		end else begin
			mag = (s < 0) ? longint'(-s) : longint'(s);
			sq = mag * mag;
		end
		if (ring_pos >= w) ring_pos = 0;
		ring_sum = ring_sum - square_ring[ring_pos] + sq;
		square_ring[ring_pos] = sq;
		ring_pos++;
		if (ring_pos >= w) ring_pos = 0;
		if (last) expected_levels.push_back(level_from_sum());
	endfunction

	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic last);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample = s;
		block_end = last;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_level(s, last);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_levels.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_window(logic [12:0] value);
		drain();
		cfg_we = 1'b1;
		window_length = value;
		@(negedge clk);
		cfg_we = 1'b0;
		meter_window = value;
		clear_meter();
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			2: return 24'($signed(16'($urandom)) >>> $urandom_range(0, 15));
			3: return 24'sd0;
			default: return 24'($signed(24'($urandom)) >>> $urandom_range(0, 22));
		endcase
	endfunction

	task automatic test_reset_window();
		for (int i = 0; i < 6; i++) send_sample(24'(1000 * i), i == 2 || i == 5);
	endtask

	task automatic test_extremes();
		send_sample(24'sd0, 1'b1);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh800000, 1'b1);
		send_sample(-24'sd1, 1'b1);
		send_sample(24'sd1, 1'b0);
		send_sample(24'sh555555, 1'b0);
		send_sample(24'shAAAAAA, 1'b1);
	endtask

	task automatic test_window_limits();
		logic [12:0] settings [6] = '{13'd0, 13'd31, 13'd32, 13'd4096, 13'd4097, 13'h1FFF};
		foreach (settings[k]) begin
			write_window(settings[k]);
			send_sample(24'sd0, 1'b1);
			for (int i = 0; i < 40; i++) send_sample(24'sh800000, i % 13 == 12);
			send_sample(24'sh7FFFFF, 1'b1);
		end
		write_window(13'd32);
		for (int i = 0; i < 70; i++) send_sample(i < 35 ? 24'sh7FFFFF : 24'sd0, i % 16 == 15);
	endtask

	task automatic test_random(int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) write_window(13'($urandom));
			else write_window($urandom_range(0, 7) == 0 ?
				13'($urandom_range(32, 4096)) : 13'($urandom_range(32, 160)));
			for (int i = 0; i < 150 && n < count; i++, n++)
				send_sample(random_sample(), $urandom_range(0, 5) == 0);
		end
	endtask

	task automatic test_silence_after_loud();
		write_window(13'd48);
		for (int i = 0; i < 130; i++)
			send_sample(i < 40 ? random_sample() : 24'sd0, i % 10 == 9);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected level_db %0d with nothing pending", level_db);
			end else begin
				if (level_db !== expected_levels[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("level_db mismatch: expected %0d, got %0d",
							expected_levels[0], level_db);
				end
				void'(expected_levels.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we
			|| (!in_valid && expected_levels.size() == 0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		meter_window = 13'd2400;
		clear_meter();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_reset_window();
		test_extremes();
		test_window_limits();
		test_silence_after_loud();
		test_random(1050);
		idle_on = 1'b0;
		test_random(200);
		drain();
		if (mismatches == 0 && expected_levels.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
